/* design/mbqd_pkg.sv */
// shared types and opcode constants for the branch and quick decoder
`default_nettype none

package mbqd_pkg;

    typedef enum logic [3:0] {
        KIND_INVALID = 4'd0,
        KIND_RESET   = 4'd1,
        KIND_NOP     = 4'd2,
        KIND_RTE     = 4'd3,
        KIND_RTS     = 4'd4,
        KIND_TRAPV   = 4'd5,
        KIND_RTR     = 4'd6,
        KIND_JSR     = 4'd7,
        KIND_JMP     = 4'd8,
        KIND_BCC     = 4'd9,
        KIND_DBCC    = 4'd10,
        KIND_SCC     = 4'd11,
        KIND_ADDQ    = 4'd12,
        KIND_SUBQ    = 4'd13
    } kind_t;

    localparam logic [15:0] OP_RESET   = 16'h4e70;
    localparam logic [15:0] OP_NOP     = 16'h4e71;
    localparam logic [15:0] OP_RTE     = 16'h4e73;
    localparam logic [15:0] OP_RTS     = 16'h4e75;
    localparam logic [15:0] OP_TRAPV   = 16'h4e76;
    localparam logic [15:0] OP_RTR     = 16'h4e77;
    localparam logic [15:0] JUMP_MASK  = 16'hffc0;
    localparam logic [15:0] OP_JSR     = 16'h4e80;
    localparam logic [15:0] OP_JMP     = 16'h4ec0;
    localparam logic [15:0] BRIEF_RSVD = 16'h0700;
    localparam logic [15:0] LINE_MASK  = 16'hf000;

    localparam logic [3:0] LINE_MISC   = 4'h4;
    localparam logic [3:0] LINE_QUICK  = 4'h5;
    localparam logic [3:0] LINE_BRANCH = 4'h6;

    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_FOUR = 3'd4;
    localparam logic [2:0] LEN_SIX  = 3'd6;

    typedef struct packed {
        logic [15:0] opcode;
        logic [15:0] ext_first;
        logic [15:0] ext_second;
        logic        ext_present;
        logic [31:0] instr_address;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         condition;
        logic [2:0]         length_bytes;
        logic [1:0]         operand_size;
        logic [3:0]         quick_value;
        logic [2:0]         ea_mode;
        logic [2:0]         ea_reg;
        logic signed [31:0] displacement;
        logic [4:0]         index_spec;
        logic               is_call;
        logic               has_target;
        logic [31:0]        target;
    } result_t;

endpackage

`default_nettype wire

/* design/mbqd_stage.sv */
// one valid/ready register stage carrying a flat payload
`default_nettype none

module mbqd_stage #(
    parameter int Width = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire logic [Width-1:0] up_data,
    output logic                  down_valid,
    input  wire logic             down_ready,
    output logic [Width-1:0]      down_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [Width-1:0] data_reg;

    // stage may refill in the same cycle its beat leaves
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

`default_nettype wire

/* design/mbqd_decode.sv */
// combinational decode of one opcode word with its extension words
`default_nettype none

module mbqd_decode
    import mbqd_pkg::*;
(
    input  wire item_t item,
    output result_t    result
);

    typedef struct packed {
        logic               ok;
        logic [2:0]         len;
        logic signed [31:0] disp;
        logic [4:0]         idx;
    } ea_res_t;

    function automatic ea_res_t ea_ext(
        input logic [2:0]  mode,
        input logic [2:0]  ea_r,
        input logic [15:0] e1,
        input logic [15:0] e2,
        input logic        ext,
        input logic        pc_ok
    );
        ea_res_t r;
        r = '0;
        priority if (mode <= 3'd4)
        begin
            r.ok  = 1'b1;
            r.len = LEN_TWO;
        end
        else if (!ext)
        begin
            r.ok = 1'b0;
        end
        else if (mode == 3'd5)
        begin
            r.ok   = 1'b1;
            r.len  = LEN_FOUR;
            r.disp = {{16{e1[15]}}, e1};
        end
        else if (mode == 3'd6 || (mode == 3'd7 && ea_r == 3'd3 && pc_ok))
        begin
            // brief extension word, reserved bits must be clear
            if ((e1 & BRIEF_RSVD) == 16'h0000)
            begin
                r.ok   = 1'b1;
                r.len  = LEN_FOUR;
                r.disp = {{24{e1[7]}}, e1[7:0]};
                r.idx  = e1[15:11];
            end
        end
        else if (ea_r == 3'd0 || (ea_r == 3'd2 && pc_ok))
        begin
            r.ok   = 1'b1;
            r.len  = LEN_FOUR;
            r.disp = {{16{e1[15]}}, e1};
        end
        else if (ea_r == 3'd1)
        begin
            r.ok   = 1'b1;
            r.len  = LEN_SIX;
            r.disp = {e1, e2};
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    logic [15:0]        op;
    logic [2:0]         mode;
    logic [2:0]         ea_r;
    logic [1:0]         sz;
    logic [2:0]         qfield;
    logic signed [31:0] bdisp;
    logic               is_jsr;
    logic               is_jump;
    logic               ok;
    ea_res_t            ea;
    result_t            d;

    assign op      = item.opcode;
    assign mode    = op[5:3];
    assign ea_r    = op[2:0];
    assign sz      = op[7:6];
    assign qfield  = op[11:9];
    assign is_jsr  = (op & JUMP_MASK) == OP_JSR;
    assign is_jump = is_jsr || ((op & JUMP_MASK) == OP_JMP);
    // pc-relative forms only exist for jsr/jmp
    assign ea      = ea_ext(mode, ea_r, item.ext_first, item.ext_second,
                            item.ext_present, op[15:12] == LINE_MISC);
    // short branch displacement of zero selects the word form
    assign bdisp   = (op[7:0] == 8'h00) ? {{16{item.ext_first[15]}}, item.ext_first}
                                        : {{24{op[7]}}, op[7:0]};

    always_comb
    begin
        d              = '0;
        d.kind         = KIND_INVALID;
        d.length_bytes = LEN_TWO;
        ok             = 1'b0;
        unique case (op[15:12])
            LINE_MISC:
            begin
                priority if (op == OP_RESET)
                begin
                    d.kind = KIND_RESET;
                    ok     = 1'b1;
                end
                else if (op == OP_NOP)
                begin
                    d.kind = KIND_NOP;
                    ok     = 1'b1;
                end
                else if (op == OP_RTE)
                begin
                    d.kind = KIND_RTE;
                    ok     = 1'b1;
                end
                else if (op == OP_RTS)
                begin
                    d.kind = KIND_RTS;
                    ok     = 1'b1;
                end
                else if (op == OP_TRAPV)
                begin
                    d.kind = KIND_TRAPV;
                    ok     = 1'b1;
                end
                else if (op == OP_RTR)
                begin
                    d.kind = KIND_RTR;
                    ok     = 1'b1;
                end
                else if (is_jump)
                begin
                    if ((mode == 3'd2 || mode >= 3'd5) && ea.ok)
                    begin
                        ok             = 1'b1;
                        d.kind         = is_jsr ? KIND_JSR : KIND_JMP;
                        d.is_call      = is_jsr;
                        d.ea_mode      = mode;
                        d.ea_reg       = ea_r;
                        d.length_bytes = ea.len;
                        d.displacement = ea.disp;
                        d.index_spec   = ea.idx;
                        if (mode == 3'd7 && ea_r <= 3'd1)
                        begin
                            d.has_target = 1'b1;
                            d.target     = ea.disp;
                        end
                        else if (mode == 3'd7 && ea_r == 3'd2)
                        begin
                            d.has_target = 1'b1;
                            d.target     = item.instr_address + 32'd2 + ea.disp;
                        end
                    end
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            LINE_QUICK:
            begin
                if (sz == 2'd3)
                begin
                    d.condition = op[11:8];
                    if (mode == 3'd1)
                    begin
                        if (item.ext_present && !item.ext_first[0])
                        begin
                            ok             = 1'b1;
                            d.kind         = KIND_DBCC;
                            d.length_bytes = LEN_FOUR;
                            d.ea_mode      = mode;
                            d.ea_reg       = ea_r;
                            d.displacement = {{16{item.ext_first[15]}}, item.ext_first};
                            d.has_target   = 1'b1;
                            d.target       = item.instr_address + 32'd2
                                           + {{16{item.ext_first[15]}}, item.ext_first};
                        end
                    end
                    else if (ea.ok)
                    begin
                        ok             = 1'b1;
                        d.kind         = KIND_SCC;
                        d.ea_mode      = mode;
                        d.ea_reg       = ea_r;
                        d.length_bytes = ea.len;
                        d.displacement = ea.disp;
                        d.index_spec   = ea.idx;
                    end
                end
                else if (!(mode == 3'd1 && sz == 2'd0) && ea.ok)
                begin
                    // byte size on an address register does not exist
                    ok             = 1'b1;
                    d.kind         = op[8] ? KIND_SUBQ : KIND_ADDQ;
                    d.operand_size = sz;
                    d.quick_value  = (qfield == 3'd0) ? 4'd8 : {1'b0, qfield};
                    d.ea_mode      = mode;
                    d.ea_reg       = ea_r;
                    d.length_bytes = ea.len;
                    d.displacement = ea.disp;
                    d.index_spec   = ea.idx;
                end
            end
            LINE_BRANCH:
            begin
                d.condition = op[11:8];
                if (!op[0] && !(op[7:0] == 8'h00 && !item.ext_present) && !bdisp[0])
                begin
                    ok             = 1'b1;
                    d.kind         = KIND_BCC;
                    d.length_bytes = (op[7:0] == 8'h00) ? LEN_FOUR : LEN_TWO;
                    d.displacement = bdisp;
                    d.is_call      = op[11:8] == 4'd1;
                    d.has_target   = 1'b1;
                    d.target       = item.instr_address + 32'd2 + bdisp;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        if (!ok)
        begin
            d              = '0;
            d.kind         = KIND_INVALID;
            d.length_bytes = LEN_TWO;
        end
    end

    assign result = d;

endmodule

`default_nettype wire

/* design/m68k_branch_quick_decoder.sv */
// top level: input register, opcode decode and result register
// Decodes one 68000 opcode word (reset, nop, rte, rts, trapv, rtr, jsr, jmp,
// Bcc/bra/bsr, DBcc, Scc, addq, subq) with its extension words and address.
// Channels: item_valid/item_ready/item carry one instruction per beat,
// result_valid/result_ready/result carry one decoded result per beat.
// Every accepted item gives exactly one result; results leave in order.
// Path: an accepted item is held in the input register, decoded there by
// combinational logic and then captured in the result register, from which
// its result is offered.
// Throughput: one item per cycle while result_ready stays high, since both
// register stages reload in the same cycle their beat is taken downstream.
// Unsupported opcodes, missing or malformed extension words and odd branch
// displacements give the invalid kind with a length of two bytes.
// Reset: both stages empty, result_valid low, item_ready high.
// Stall: while result_ready is low the result holds; the input register
// still takes one more item, then item_ready falls until the result drains.
`default_nettype none

module m68k_branch_quick_decoder
    import mbqd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_ready,
    output result_t    result
);

    logic    dec_valid;
    logic    dec_ready;
    item_t   dec_item;
    result_t dec_result;

    mbqd_stage #(
        .Width($bits(item_t))
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (item_valid),
        .up_ready  (item_ready),
        .up_data   (item),
        .down_valid(dec_valid),
        .down_ready(dec_ready),
        .down_data (dec_item)
    );

    mbqd_decode u_decode (
        .item  (dec_item),
        .result(dec_result)
    );

    mbqd_stage #(
        .Width($bits(result_t))
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (dec_valid),
        .up_ready  (dec_ready),
        .up_data   (dec_result),
        .down_valid(result_valid),
        .down_ready(result_ready),
        .down_data (result)
    );

    // invalid beats carry nothing but the two-byte length
    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_INVALID |->
            result.length_bytes == LEN_TWO && result.target == 32'd0
            && result.has_target == 1'b0 && result.displacement == 32'sd0)
        else $error("invalid result carries stray fields");

    a_length_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.length_bytes == LEN_TWO || result.length_bytes == LEN_FOUR
            || result.length_bytes == LEN_SIX)
        else $error("illegal instruction length");

    a_target_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.has_target |->
            result.kind == KIND_JSR || result.kind == KIND_JMP
            || result.kind == KIND_BCC || result.kind == KIND_DBCC)
        else $error("static target on a kind that has none");

    a_call_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_call |->
            result.kind == KIND_JSR || result.kind == KIND_BCC)
        else $error("call flag on a non-call kind");

    // a full pipe with a stalled receiver must back-pressure the sender
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && result_valid && !result_ready |-> !item_ready)
        else $error("input taken while both stages are full");

endmodule

`default_nettype wire
